// ===== src/lzsd_pkg.sv =====
// ============================================================================
// lzsd_pkg
// Shared types and constants of the LZSS stream decoder.
// ============================================================================
package lzsd_pkg;

    // One input beat
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    // One result beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       copy_pending;
        logic       last;
    } t_out_item;

    // func codes
    localparam logic FUNC_STREAM = 1'b0;
    localparam logic FUNC_DRAIN  = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_DIST  = 3'd2;
    localparam logic [2:0] ST_OVERRUN   = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;
    localparam logic [2:0] ST_NONE      = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;

    // header layout
    localparam logic [3:0] MAGIC_BYTES = 4'd4;
    localparam logic [3:0] HDR_BYTES   = 4'd12;
    localparam logic [3:0] FLAG_ITEMS  = 4'd8;
    localparam logic [1:0] TOK_LAST    = 2'd3;

    // "CLSS"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h43;
            2'd1:    b = 8'h4C;
            default: b = 8'h53;
        endcase
        return b;
    endfunction

endpackage

// ===== src/lzsd_ram.sv =====
// ============================================================================
// lzsd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module lzsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lzss_stream_decoder_top.sv =====
// ============================================================================
// lzss_stream_decoder_top
// LZSS stream decoder: header check, flag/literal/token parsing, history copy.
// ============================================================================
// Takes the compressed stream one byte per input beat and returns decoded
// bytes as result beats, each tagged with a status code, a copy-pending flag
// and a last marker. The stream opens with the magic "CLSS" and an 8-byte
// little-endian declared length, then flag bytes that each govern eight
// literals or 4-byte copy tokens (16-bit distance, 16-bit length). One input
// beat yields at most BURST copy bytes; the rest comes out on drain beats.
// Flow: an input beat is registered, then decoded once the output register
// is free. For a copy, each byte is read from the history memory at the
// source pointer (S_RD), then written back and presented (S_WR), which also
// makes overlapping copies (distance below length) safe without forwarding.
// The history memory holds HISTORY_DEPTH bytes and needs no clearing after
// reset: distances are checked against the number of bytes written before
// any read. Errors are sticky until reset; every later beat returns one
// result with the latched code.
// ============================================================================
module lzss_stream_decoder_top
    import lzsd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536,
    parameter int BURST         = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int BC_W   = $clog2(BURST + 1);

    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an input beat
    localparam logic [1:0] S_EXEC = 2'd1;  // decode the registered beat
    localparam logic [1:0] S_RD   = 2'd2;  // history read at source pointer
    localparam logic [1:0] S_WR   = 2'd3;  // write back + emit copy byte

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    logic [1:0]        r_state,     n_state;
    t_in_item          r_item,      n_item;
    logic [3:0]        r_hdr_cnt,   n_hdr_cnt;
    logic [63:0]       r_room,      n_room;      // declared length - written
    logic [7:0]        r_flag_bits, n_flag_bits;
    logic [3:0]        r_flag_pos,  n_flag_pos;  // 8 = next body byte is a flag
    logic [1:0]        r_tok_cnt,   n_tok_cnt;
    logic [23:0]       r_tok_word,  n_tok_word;  // first three token bytes
    logic [15:0]       r_copy_rem,  n_copy_rem;
    logic [AW-1:0]     r_src_ptr,   n_src_ptr;
    logic [AW-1:0]     r_wr_ptr,    n_wr_ptr;
    logic [FILL_W-1:0] r_fill,      n_fill;      // bytes written, saturating
    logic [BC_W-1:0]   r_burst_cnt, n_burst_cnt;
    logic              r_run_pend,  n_run_pend;
    logic              r_err,       n_err;
    logic [2:0]        r_err_code,  n_err_code;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    // history memory ports
    logic          ram_we;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    lzsd_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_src_ptr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Token fields and checks (valid on the fourth token byte)
    // ------------------------------------------------------------------------
    logic [15:0]   tok_dist;
    logic [15:0]   tok_len;
    logic          bad_dist;
    logic          copy_overrun;
    logic [31:0]   src_diff;
    logic [AW-1:0] tok_src;
    logic          slot_free;

    assign tok_dist     = r_tok_word[15:0];
    assign tok_len      = {r_item.data_byte, r_tok_word[23:16]};
    // fill saturates at the depth, so this also rejects distances beyond it
    assign bad_dist     = (tok_dist == 16'd0) || (32'(tok_dist) > 32'(r_fill));
    assign copy_overrun = 64'(tok_len) > r_room;
    assign src_diff     = 32'(r_wr_ptr) - 32'(tok_dist);
    assign tok_src      = (32'(r_wr_ptr) < 32'(tok_dist))
                        ? AW'(src_diff + 32'(HISTORY_DEPTH))
                        : AW'(src_diff);
    assign slot_free    = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    logic        emit;
    t_out_item   emit_item;
    logic        raise;
    logic [2:0]  raise_code;
    logic        adv;          // one byte into history
    logic        start_run;
    logic [15:0] run_rem;
    logic [15:0] run_n;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_hdr_cnt   = r_hdr_cnt;
        n_room      = r_room;
        n_flag_bits = r_flag_bits;
        n_flag_pos  = r_flag_pos;
        n_tok_cnt   = r_tok_cnt;
        n_tok_word  = r_tok_word;
        n_copy_rem  = r_copy_rem;
        n_src_ptr   = r_src_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_fill      = r_fill;
        n_burst_cnt = r_burst_cnt;
        n_run_pend  = r_run_pend;
        n_err       = r_err;
        n_err_code  = r_err_code;

        emit       = 1'b0;
        emit_item  = '0;
        raise      = 1'b0;
        raise_code = ST_OK;
        adv        = 1'b0;
        ram_wdata  = r_item.data_byte;
        ram_re     = 1'b0;
        start_run  = 1'b0;
        run_rem    = r_copy_rem;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                    if (r_err) begin
                        emit      = 1'b1;
                        emit_item = '{8'd0, r_err_code, 1'b0, 1'b1};
                    end else if (r_item.func == FUNC_DRAIN) begin
                        if (r_copy_rem == 16'd0) begin
                            emit      = 1'b1;
                            emit_item = '{8'd0, ST_NONE, 1'b0, 1'b1};
                        end else begin
                            start_run = 1'b1;
                        end
                    end else if (r_copy_rem != 16'd0) begin
                        // byte not consumed, stream_end ignored
                        emit      = 1'b1;
                        emit_item = '{8'd0, ST_BUSY, 1'b1, 1'b1};
                    end else if (r_hdr_cnt != HDR_BYTES) begin
                        if (r_hdr_cnt < MAGIC_BYTES) begin
                            if (r_item.data_byte != magic_byte(r_hdr_cnt[1:0])) begin
                                raise      = 1'b1;
                                raise_code = ST_BAD_MAGIC;
                            end
                        end else begin
                            n_room[{3'(r_hdr_cnt - MAGIC_BYTES), 3'b000} +: 8] =
                                r_item.data_byte;
                        end
                        n_hdr_cnt = r_hdr_cnt + 4'd1;
                        if (!raise && r_item.stream_end && n_hdr_cnt != HDR_BYTES) begin
                            raise      = 1'b1;
                            raise_code = ST_TRUNC;
                        end
                    end else if (r_flag_pos[3]) begin
                        n_flag_bits = r_item.data_byte;
                        n_flag_pos  = 4'd0;
                    end else if (!r_flag_bits[r_flag_pos[2:0]]) begin
                        // literal
                        if (r_room == 64'd0) begin
                            raise      = 1'b1;
                            raise_code = ST_OVERRUN;
                        end else begin
                            adv        = 1'b1;
                            n_flag_pos = r_flag_pos + 4'd1;
                            emit       = 1'b1;
                            emit_item  = '{r_item.data_byte, ST_OK, 1'b0, 1'b1};
                        end
                    end else if (r_tok_cnt != TOK_LAST) begin
                        n_tok_word[{r_tok_cnt, 3'b000} +: 8] = r_item.data_byte;
                        n_tok_cnt = r_tok_cnt + 2'd1;
                        if (r_item.stream_end) begin
                            raise      = 1'b1;
                            raise_code = ST_TRUNC;
                        end
                    end else begin
                        n_tok_word = '0;
                        n_tok_cnt  = 2'd0;
                        n_flag_pos = r_flag_pos + 4'd1;
                        if (bad_dist) begin
                            raise      = 1'b1;
                            raise_code = ST_BAD_DIST;
                        end else if (copy_overrun) begin
                            raise      = 1'b1;
                            raise_code = ST_OVERRUN;
                        end else if (tok_len != 16'd0) begin
                            n_src_ptr = tok_src;
                            run_rem   = tok_len;
                            start_run = 1'b1;
                        end
                    end
                end
            end

            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_WR;
            end

            S_WR: begin
                if (slot_free) begin
                    adv         = 1'b1;
                    ram_wdata   = ram_rdata;
                    emit        = 1'b1;
                    emit_item   = '{ram_rdata, ST_OK, r_run_pend,
                                    r_burst_cnt == BC_W'(1)};
                    n_src_ptr   = (r_src_ptr == AW'(HISTORY_DEPTH - 1))
                                ? '0 : r_src_ptr + AW'(1);
                    n_burst_cnt = r_burst_cnt - BC_W'(1);
                    n_state     = (r_burst_cnt == BC_W'(1)) ? S_IDLE : S_RD;
                end
            end

            default: n_state = S_IDLE;
        endcase

        // new burst out of the pending copy
        run_n = (32'(run_rem) < 32'(BURST)) ? run_rem : 16'(BURST);
        if (start_run) begin
            n_burst_cnt = BC_W'(run_n);
            n_copy_rem  = run_rem - run_n;
            n_run_pend  = 32'(run_rem) > 32'(BURST);
            n_state     = S_RD;
        end

        // byte into history
        ram_we = adv;
        if (adv) begin
            n_wr_ptr = (r_wr_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            n_room   = r_room - 64'd1;
            if (r_fill != FILL_W'(HISTORY_DEPTH)) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end

        // sticky error
        if (raise) begin
            n_err      = 1'b1;
            n_err_code = raise_code;
            n_copy_rem = 16'd0;
            emit       = 1'b1;
            emit_item  = '{8'd0, raise_code, 1'b0, 1'b1};
        end

        // output register
        n_out = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = emit_item;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hdr_cnt   <= 4'd0;
            r_room      <= 64'd0;
            r_flag_bits <= 8'd0;
            r_flag_pos  <= FLAG_ITEMS;
            r_tok_cnt   <= 2'd0;
            r_tok_word  <= 24'd0;
            r_copy_rem  <= 16'd0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_burst_cnt <= '0;
            r_err       <= 1'b0;
            r_err_code  <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hdr_cnt   <= n_hdr_cnt;
            r_room      <= n_room;
            r_flag_bits <= n_flag_bits;
            r_flag_pos  <= n_flag_pos;
            r_tok_cnt   <= n_tok_cnt;
            r_tok_word  <= n_tok_word;
            r_copy_rem  <= n_copy_rem;
            r_wr_ptr    <= n_wr_ptr;
            r_fill      <= n_fill;
            r_burst_cnt <= n_burst_cnt;
            r_err       <= n_err;
            r_err_code  <= n_err_code;
            r_out_valid <= n_out_valid;
        end
        r_item     <= n_item;
        r_src_ptr  <= n_src_ptr;
        r_run_pend <= n_run_pend;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> $past(r_state) == S_RD || $past(r_state) == S_WR)
        else $error("history write-back without a preceding read");

    a_burst_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_WR) |-> r_burst_cnt != '0)
        else $error("copy burst running with zero count");

    a_err_no_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> r_copy_rem == 16'd0)
        else $error("copy still pending after error");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HISTORY_DEPTH))
        else $error("history fill count beyond depth");

endmodule

// ===== verif/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the LZSS stream decoder.
// ============================================================================
// A scripted opening walks the header, literals, an overlapping copy, a busy
// beat, drains and a zero-length copy. A stream generator then keeps
// producing well-formed flag/literal/token traffic, with some noise beats.
// It steers from the reference state, so copies never reach past the bytes
// written or past the declared length. The run closes with one fatal stream
// error, picked at random from bad distance, length overrun and truncated
// token, and a few beats that must echo the latched code. Every result beat is
// checked field by field against an in-bench decoder.
// ============================================================================
module testbench
    import lzsd_pkg::*;
;

    localparam int HIST_DEPTH = 65536;
    localparam int BURST_LEN  = 16;
    localparam int RAND_BEATS = 340;
    localparam int CYCLE_CAP  = 800000;
    localparam int MAX_REPORTS = 100;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT hookup
    // ------------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_beat   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_beat;

    initial begin
        forever #1 clk = ~clk;
    end

    lzss_stream_decoder_top #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .BURST        (BURST_LEN)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_beat)
    );

    // ------------------------------------------------------------------------
    // Reference decoder state (reset values as the block comes out of reset)
    // ------------------------------------------------------------------------
    localparam logic [7:0] MAGIC_TEXT [4] = '{8'h43, 8'h4C, 8'h53, 8'h53};

    int          hdr_cnt    = 0;
    logic [63:0] decl_len   = '0;
    logic [7:0]  flag_byte  = '0;
    int          flag_idx   = 8;       // 8 = next body byte is a flag byte
    int          tok_cnt    = 0;
    logic [31:0] tok_acc    = '0;
    int          copy_left  = 0;
    int          copy_dist  = 0;
    logic [63:0] out_count  = '0;
    logic [7:0]  hist [HIST_DEPTH];
    logic        fault      = 1'b0;
    logic [2:0]  fault_code = ST_OK;

    t_out_item decoded_q [$];          // decoded beats still owed by the DUT

    int errors = 0;
    int cycles = 0;
    int send_idle = 0;                 // percent of cycles the sender holds off
    int recv_idle = 0;                 // percent of cycles the receiver stalls

    function automatic void queue_beat(input logic [7:0] b, input logic [2:0] st,
                                       input logic pend, input logic lst);
        decoded_q.push_back(t_out_item'{b, st, pend, lst});
    endfunction

    // Sticky error: one beat now, the same code on every later beat.
    function automatic void trip(input logic [2:0] code);
        fault      = 1'b1;
        fault_code = code;
        copy_left  = 0;
        queue_beat(8'h00, code, 1'b0, 1'b1);
    endfunction

    function automatic void put_hist(input logic [7:0] b);
        hist[out_count % HIST_DEPTH] = b;
        out_count++;
    endfunction

    // One burst of the pending copy; pending flag is the same on every beat.
    function automatic void replay_burst();
        int   n;
        logic pend;
        logic [7:0] b;
        n = (copy_left < BURST_LEN) ? copy_left : BURST_LEN;
        copy_left -= n;
        pend = (copy_left != 0);
        for (int k = 0; k < n; k++) begin
            b = hist[(out_count - copy_dist) % HIST_DEPTH];
            put_hist(b);
            queue_beat(b, ST_OK, pend, k == n - 1);
        end
    endfunction

    function automatic void decode_step(input t_in_item it);
        int cp_dist;
        int len;
        if (fault) begin
            queue_beat(8'h00, fault_code, 1'b0, 1'b1);
            return;
        end
        if (it.func == FUNC_DRAIN) begin
            if (copy_left == 0) queue_beat(8'h00, ST_NONE, 1'b0, 1'b1);
            else replay_burst();
            return;
        end
        // stream byte during a pending copy is bounced, stream_end ignored
        if (copy_left != 0) begin
            queue_beat(8'h00, ST_BUSY, 1'b1, 1'b1);
            return;
        end
        // header: magic, then 8-byte little-endian declared length
        if (hdr_cnt < HDR_BYTES) begin
            if (hdr_cnt < MAGIC_BYTES) begin
                if (it.data_byte != MAGIC_TEXT[hdr_cnt]) begin
                    trip(ST_BAD_MAGIC);
                    return;
                end
            end else begin
                decl_len[8*(hdr_cnt-MAGIC_BYTES) +: 8] = it.data_byte;
            end
            hdr_cnt++;
            if (hdr_cnt < HDR_BYTES && it.stream_end) trip(ST_TRUNC);
            return;
        end
        if (flag_idx >= FLAG_ITEMS) begin
            flag_byte = it.data_byte;
            flag_idx  = 0;
            return;
        end
        if (!flag_byte[flag_idx]) begin
            if (out_count >= decl_len) begin
                trip(ST_OVERRUN);
                return;
            end
            put_hist(it.data_byte);
            flag_idx++;
            queue_beat(it.data_byte, ST_OK, 1'b0, 1'b1);
            return;
        end
        tok_acc[8*tok_cnt +: 8] = it.data_byte;
        if (tok_cnt < TOK_LAST) begin
            tok_cnt++;
            if (it.stream_end) trip(ST_TRUNC);
            return;
        end
        cp_dist  = int'(tok_acc[15:0]);
        len      = int'(tok_acc[31:16]);
        tok_acc  = '0;
        tok_cnt  = 0;
        flag_idx++;
        if (cp_dist == 0 || cp_dist > out_count || cp_dist > HIST_DEPTH) begin
            trip(ST_BAD_DIST);
        end else if (len > decl_len - out_count) begin
            trip(ST_OVERRUN);
        end else begin
            copy_dist = cp_dist;
            copy_left = len;
            if (len != 0) replay_burst();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stream generator
    // ------------------------------------------------------------------------
    typedef enum int {END_BAD_DIST, END_OVERRUN, END_TRUNC} t_ending;

    logic        finale   = 1'b0;      // steering toward the closing error
    t_ending     ending   = END_BAD_DIST;
    logic        big_due  = 1'b0;      // next token is a long copy
    logic [31:0] tok_plan = '0;
    int          trunc_at = 3;

    function automatic void plan_token();
        int wr;
        int lim;
        int room;
        int pick;
        int d;
        int l;
        wr   = int'(out_count);
        lim  = (wr < 65535) ? wr : 65535;
        room = int'(decl_len - out_count) - 64;
        if (room < 0) room = 0;
        // half the time short, overlapping distances; otherwise anywhere in history
        d = $urandom_range(1) ? $urandom_range(1, (lim < 8) ? lim : 8)
                              : $urandom_range(1, lim);
        pick = $urandom_range(99);
        if (pick < 10)      l = 0;
        else if (pick < 70) l = $urandom_range(1, 20);
        else if (pick < 95) l = $urandom_range(21, 80);
        else                l = $urandom_range(81, 300);
        if (big_due) begin
            l = 1024 + $urandom_range(64);
            big_due = 1'b0;
        end
        if (l > room) l = room;
        if (finale) begin
            case (ending)
                END_BAD_DIST: begin
                    d = $urandom_range(1) ? 0 : wr + 1;
                end
                END_OVERRUN: begin
                    // remaining budget is always below 64K here
                    d = 1;
                    l = 16'hFFFF;
                end
                default: begin
                    trunc_at = $urandom_range(2);
                end
            endcase
        end
        tok_plan = {l[15:0], d[15:0]};
    endfunction

    function automatic t_in_item next_beat();
        t_in_item it;
        it.func       = FUNC_STREAM;
        it.data_byte  = 8'($urandom);
        it.stream_end = 1'($urandom);
        // noise: idle drain, or a stream byte that bounces off a pending copy
        if ($urandom_range(99) < 6) begin
            if (copy_left == 0) it.func = FUNC_DRAIN;
            return it;
        end
        if (copy_left != 0) begin
            it.func = FUNC_DRAIN;
            return it;
        end
        if (flag_idx >= FLAG_ITEMS) begin
            if (finale) it.data_byte = 8'hFF;
            return it;
        end
        if (!flag_byte[flag_idx]) return it;           // literal
        if (tok_cnt == 0) plan_token();
        it.data_byte = tok_plan[8*tok_cnt +: 8];
        // within a token, stream end is only harmless on the fourth byte
        if (tok_cnt != TOK_LAST)
            it.stream_end = finale && ending == END_TRUNC && tok_cnt == trunc_at;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Input driver: valid holds until accepted, prediction at acceptance
    // ------------------------------------------------------------------------
    task automatic send_item(input t_in_item beat, input bit typed = 1'b0,
                             input t_out_item want = '0);
        int n0;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n0 = decoded_q.size();
        decode_step(beat);
        // scripted rows with a known answer replace the predicted beat
        if (typed) begin
            while (decoded_q.size() > n0) void'(decoded_q.pop_back());
            decoded_q.push_back(want);
        end
    endtask

    // Sender goes quiet until every owed beat has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Scripted opening
    // ------------------------------------------------------------------------
    typedef struct packed {
        t_in_item  beat;
        logic      typed;
        t_out_item want;
    } t_row;

    localparam t_out_item NOCHK = '0;

    localparam int N_ROWS = 27;
    localparam t_row SCRIPT [N_ROWS] = '{
        // drain straight after reset: nothing pending
        '{'{FUNC_DRAIN,  8'h00, 1'b0}, 1'b1, '{8'h00, ST_NONE, 1'b0, 1'b1}},
        // magic
        '{'{FUNC_STREAM, 8'h43, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h4C, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h53, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h53, 1'b0}, 1'b0, NOCHK},
        // declared length 0xC000, stream end on the twelfth byte is legal
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'hC0, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b1}, 1'b0, NOCHK},
        // flag: literal, literal, token, token, then literals
        '{'{FUNC_STREAM, 8'h0C, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b1, '{8'h00, ST_OK, 1'b0, 1'b1}},
        '{'{FUNC_STREAM, 8'hFF, 1'b1}, 1'b1, '{8'hFF, ST_OK, 1'b0, 1'b1}},
        // distance 2 = all bytes written, length 20: overlapping, spills over
        '{'{FUNC_STREAM, 8'h02, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h14, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        // stream byte while the copy is pending bounces
        '{'{FUNC_STREAM, 8'h77, 1'b1}, 1'b1, '{8'h00, ST_BUSY, 1'b1, 1'b1}},
        '{'{FUNC_DRAIN,  8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_DRAIN,  8'hFF, 1'b0}, 1'b1, '{8'h00, ST_NONE, 1'b0, 1'b1}},
        // zero-length copy: no beat at all
        '{'{FUNC_STREAM, 8'h01, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b0}, 1'b0, NOCHK},
        '{'{FUNC_STREAM, 8'h00, 1'b1}, 1'b0, NOCHK}
    };

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle = 18;
        recv_idle = 88;
        for (int i = 0; i < N_ROWS; i++)
            send_item(SCRIPT[i].beat, SCRIPT[i].typed, SCRIPT[i].want);

        for (int n = 0; n < RAND_BEATS; n++) begin
            if (n == RAND_BEATS / 3) begin
                wait_drained();
                send_idle = 88;
                recv_idle = 18;
            end
            if (n == 2 * RAND_BEATS / 3) begin
                wait_drained();
                send_idle = 0;
                recv_idle = 0;
                big_due   = 1'b1;
            end
            send_item(next_beat());
        end

        // close on one fatal error, then show that it sticks
        finale = 1'b1;
        ending = t_ending'($urandom_range(2));
        while (!fault) send_item(next_beat());
        repeat (6) send_item(next_beat());

        wait_drained();
        repeat (2 * BURST_LEN + 8) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver stalls and result check
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk) begin : check_out
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (decoded_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: beat with nothing owed: got %p", $time, out_beat);
            end else begin
                want = decoded_q.pop_front();
                if (out_beat !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        if (out_beat.out_byte !== want.out_byte)
                            $display("%0t: out_byte expected %h got %h", $time,
                                     want.out_byte, out_beat.out_byte);
                        if (out_beat.status !== want.status)
                            $display("%0t: status expected %0d got %0d", $time,
                                     want.status, out_beat.status);
                        if (out_beat.copy_pending !== want.copy_pending)
                            $display("%0t: copy_pending expected %b got %b", $time,
                                     want.copy_pending, out_beat.copy_pending);
                        if (out_beat.last !== want.last)
                            $display("%0t: last expected %b got %b", $time,
                                     want.last, out_beat.last);
                    end
                end
            end
        end
    end

    // hang guard
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
